/* rtl/accu_pkg.sv */
package accu_pkg;

  // History sizing
  localparam int HISTORY_DEPTH = 16;
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  // Field widths
  localparam int DATA_W  = 32;
  localparam int OPC_W   = 2;
  localparam int OPER_W  = 3;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;

  // Opcodes: only the high bit selects history reset
  localparam logic [OPC_W-1:0] OPC_COMPUTE   = 2'd0;
  localparam logic [OPC_W-1:0] OPC_UNDO      = 2'd1;
  localparam logic [OPC_W-1:0] OPC_RESET     = 2'd2;
  localparam logic [OPC_W-1:0] OPC_RESET_ALT = 2'd3;

  // Operators: remaining codes pass the left operand through
  localparam logic [OPER_W-1:0] OPER_ADD = 3'd0;
  localparam logic [OPER_W-1:0] OPER_SUB = 3'd1;
  localparam logic [OPER_W-1:0] OPER_MUL = 3'd2;
  localparam logic [OPER_W-1:0] OPER_DIV = 3'd3;
  localparam logic [OPER_W-1:0] OPER_REM = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    ST_COMPUTED   = 3'd0,
    ST_UNDONE     = 3'd1,
    ST_EMPTIED    = 3'd2,
    ST_NO_HISTORY = 3'd3,
    ST_DIV_ZERO   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RES_ALU,
    RES_PROD,
    RES_QUO,
    RES_REM,
    RES_MEM,
    RES_ZERO
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     latch;
    logic     clear;
    logic     pop;
    logic     push;
    logic     ld_res;
    res_sel_t res_sel;
    status_t  res_status;
    logic     mul_ld;
    logic     div_start;
    logic     ld_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [OPER_W-1:0] oper;
    logic              cnt_zero;
    logic              cnt_one;
    logic              b_zero;
    logic              div_done;
  } sts_t;

endpackage

/* rtl/accu_div.sv */
module accu_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [accu_pkg::DATA_W-1:0] dividend,
  input  logic signed [accu_pkg::DATA_W-1:0] divisor,
  output logic                              done,
  output logic signed [accu_pkg::DATA_W-1:0] quotient,
  output logic signed [accu_pkg::DATA_W-1:0] remainder
);
  import accu_pkg::*;

  localparam int STEP_W = $clog2(DATA_W + 1);

  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] den_r;
  logic              neg_q_r;
  logic              neg_r_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, quo_r[DATA_W-1]};
    diff    = shifted - {1'b0, den_r};
    fits    = (shifted >= {1'b0, den_r});
  end

  // Iterate over magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        step_r  <= STEP_W'(DATA_W);
        quo_r   <= dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
        den_r   <= divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
        rem_r   <= '0;
        neg_q_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        neg_r_r <= dividend[DATA_W-1];
      end else if (busy_r) begin
        rem_r  <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_r  <= {quo_r[DATA_W-2:0], fits};
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Restore signs: quotient truncates toward zero, remainder follows the dividend
  assign quotient  = neg_q_r ? -$signed(quo_r) : $signed(quo_r);
  assign remainder = neg_r_r ? -$signed(rem_r) : $signed(rem_r);
  assign done      = done_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("divider not busy after start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && (step_r == '0))
    else $error("divider done while still iterating");

endmodule

/* rtl/accu_dpath.sv */
module accu_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  accu_pkg::cmd_t                      cmd,
  output accu_pkg::sts_t                      sts,
  input  logic        [accu_pkg::OPC_W-1:0]   in_opcode,
  input  logic        [accu_pkg::OPER_W-1:0]  in_operator,
  input  logic signed [accu_pkg::DATA_W-1:0]  in_operand_a,
  input  logic signed [accu_pkg::DATA_W-1:0]  in_operand_b,
  output logic signed [accu_pkg::DATA_W-1:0]  out_value,
  output logic        [accu_pkg::STAT_W-1:0]  out_status,
  output logic        [accu_pkg::COUNT_W-1:0] out_history_count
);
  import accu_pkg::*;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);

  logic [DATA_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [IDX_W-1:0]  top_r;
  logic [IDX_W-1:0]  top_up;
  logic [IDX_W-1:0]  top_down;
  logic [CNT_W-1:0]  count_r;

  logic [OPC_W-1:0]  opcode_r;
  logic [OPER_W-1:0] oper_r;
  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] b_r;

  logic [DATA_W-1:0] left;
  logic [DATA_W-1:0] alu;
  logic [DATA_W-1:0] prod_r;
  logic [DATA_W-1:0] res_sel_val;

  logic [DATA_W-1:0] res_value_r;
  status_t           res_status_r;
  logic [DATA_W-1:0] out_value_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_count_r;

  logic                     div_done;
  logic signed [DATA_W-1:0] div_quo;
  logic signed [DATA_W-1:0] div_rem;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      opcode_r <= in_opcode;
      oper_r   <= in_operator;
      a_r      <= in_operand_a;
      b_r      <= in_operand_b;
    end
  end

  // Circular neighbours of the top slot
  assign top_up   = (top_r == IDX_LAST) ? '0 : top_r + 1'b1;
  assign top_down = (top_r == '0) ? IDX_LAST : top_r - 1'b1;

  // Left operand and the combinational operations
  assign left = (count_r == '0) ? a_r : rd_data_r;

  always_comb begin
    case (oper_r)
      OPER_ADD: alu = left + b_r;
      OPER_SUB: alu = left - b_r;
      default:  alu = left;
    endcase
  end

  // Register the low word of the product
  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      prod_r <= left * b_r;
    end
  end

  accu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  ($signed(left)),
    .divisor   ($signed(b_r)),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Pick the result source
  always_comb begin
    case (cmd.res_sel)
      RES_ALU:  res_sel_val = alu;
      RES_PROD: res_sel_val = prod_r;
      RES_QUO:  res_sel_val = div_quo;
      RES_REM:  res_sel_val = div_rem;
      RES_MEM:  res_sel_val = rd_data_r;
      default:  res_sel_val = '0;
    endcase
  end

  // History memory: write on push, read the top slot every cycle
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hist_mem[top_up] <= res_sel_val;
    end
    rd_data_r <= hist_mem[top_r];
  end

  // Advance, drop or clear the top pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= '0;
      count_r <= '0;
    end else if (cmd.clear) begin
      top_r   <= '0;
      count_r <= '0;
    end else if (cmd.push) begin
      top_r <= top_up;
      if (count_r != CNT_FULL) begin
        count_r <= count_r + 1'b1;
      end
    end else if (cmd.pop) begin
      top_r   <= top_down;
      count_r <= count_r - 1'b1;
    end
  end

  // Result and output registers
  always_ff @(posedge clk) begin
    if (cmd.ld_res) begin
      res_value_r  <= res_sel_val;
      res_status_r <= cmd.res_status;
    end
    if (cmd.ld_out) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
    end
  end

  assign out_value         = $signed(out_value_r);
  assign out_status        = out_status_r;
  assign out_history_count = COUNT_W'(out_count_r);

  // Status back to the controller
  assign sts.opcode   = opcode_r;
  assign sts.oper     = oper_r;
  assign sts.cnt_zero = (count_r == '0);
  assign sts.cnt_one  = (count_r == CNT_W'(1));
  assign sts.b_zero   = (b_r == '0);
  assign sts.div_done = div_done;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("history count beyond depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (count_r == '0) && (top_r == '0))
    else $error("history not empty after clear");

endmodule

/* rtl/accu_ctrl.sv */
module accu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  accu_pkg::sts_t sts,
  output accu_pkg::cmd_t cmd
);
  import accu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_UNDO_WAIT,
    S_UNDO_LD,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Decode state and status into datapath commands
  always_comb begin
    cmd            = '0;
    cmd.res_sel    = RES_ZERO;
    cmd.res_status = ST_COMPUTED;
    state_nxt      = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        unique case (sts.opcode) inside
          OPC_COMPUTE: begin
            state_nxt = S_EXEC;
          end
          OPC_UNDO: begin
            if (sts.cnt_zero) begin
              cmd.ld_res     = 1'b1;
              cmd.res_status = ST_NO_HISTORY;
              state_nxt      = S_DONE;
            end else if (sts.cnt_one) begin
              cmd.pop        = 1'b1;
              cmd.ld_res     = 1'b1;
              cmd.res_status = ST_EMPTIED;
              state_nxt      = S_DONE;
            end else begin
              cmd.pop   = 1'b1;
              state_nxt = S_UNDO_WAIT;
            end
          end
          OPC_RESET, OPC_RESET_ALT: begin
            cmd.clear      = 1'b1;
            cmd.ld_res     = 1'b1;
            cmd.res_status = ST_EMPTIED;
            state_nxt      = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_EXEC: begin
        unique case (sts.oper) inside
          OPER_MUL: begin
            cmd.mul_ld = 1'b1;
            state_nxt  = S_MUL;
          end
          OPER_DIV, OPER_REM: begin
            if (sts.b_zero) begin
              cmd.ld_res     = 1'b1;
              cmd.res_status = ST_DIV_ZERO;
              state_nxt      = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            cmd.res_sel = RES_ALU;
            cmd.ld_res  = 1'b1;
            cmd.push    = 1'b1;
            state_nxt   = S_DONE;
          end
        endcase
      end
      S_MUL: begin
        cmd.res_sel = RES_PROD;
        cmd.ld_res  = 1'b1;
        cmd.push    = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.res_sel = (sts.oper == OPER_REM) ? RES_REM : RES_QUO;
          cmd.ld_res  = 1'b1;
          cmd.push    = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_UNDO_WAIT: begin
        state_nxt = S_UNDO_LD;
      end
      S_UNDO_LD: begin
        cmd.res_sel    = RES_MEM;
        cmd.ld_res     = 1'b1;
        cmd.res_status = ST_UNDONE;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_FETCH)
    else $error("accepted transfer not followed by fetch");

  a_push_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !cmd.pop && !cmd.clear && cmd.ld_res)
    else $error("push issued with a conflicting history command");

endmodule

/* rtl/accumulator_alu_with_undo_stack.sv */
// Signed 32-bit accumulator calculator with a 16-entry undo history. An item
// is taken only while the block is idle, and its result goes to an output
// register, so the next item may be taken while that result still waits.
// Add, subtract and pass-through results are loaded in the execute state;
// multiply first registers the product, and divide and remainder wait for
// the radix-2 divider, which resolves one quotient bit per cycle. An undo
// that leaves entries waits for the registered read of the new top slot. A
// held output keeps the block in its done state until the output is free.
// The history lives in a small memory with a registered read port at the top
// slot; when full, a push overwrites the oldest entry.
module accumulator_alu_with_undo_stack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [accu_pkg::OPC_W-1:0]   in_opcode,
  input  logic        [accu_pkg::OPER_W-1:0]  in_operator,
  input  logic signed [accu_pkg::DATA_W-1:0]  in_operand_a,
  input  logic signed [accu_pkg::DATA_W-1:0]  in_operand_b,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [accu_pkg::DATA_W-1:0]  out_value,
  output logic        [accu_pkg::STAT_W-1:0]  out_status,
  output logic        [accu_pkg::COUNT_W-1:0] out_history_count
);
  import accu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  accu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  accu_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_opcode),
    .in_operator       (in_operator),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_value         (out_value),
    .out_status        (out_status),
    .out_history_count (out_history_count)
  );

endmodule

/* sim/accumulator_alu_with_undo_stack_tb.sv */
`timescale 1ns / 1ps

module accumulator_alu_with_undo_stack_tb;
  import accu_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int ITEM_TARGET  = 1550;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_NEG_ONE = '1;

  // Operator codes past remainder pass the left operand through
  localparam logic [OPER_W-1:0] OPER_PASS_FIRST = 3'd5;
  localparam logic [OPER_W-1:0] OPER_PASS_LAST  = 3'd7;

  typedef struct {
    logic [OPC_W-1:0]         opcode;
    logic [OPER_W-1:0]        oper;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } calc_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic [COUNT_W-1:0]       count;
  } calc_result_t;

  typedef enum int {STALL_NONE, STALL_SCATTER, STALL_RUNS} stall_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OPC_W-1:0]          in_opcode = '0;
  logic [OPER_W-1:0]         in_operator = '0;
  logic signed [DATA_W-1:0]  in_operand_a = '0;
  logic signed [DATA_W-1:0]  in_operand_b = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  out_value;
  logic [STAT_W-1:0]         out_status;
  logic [COUNT_W-1:0]        out_history_count;

  calc_cmd_t    cmd_queue [$];
  calc_result_t pending_results [$];

  // Predictor copy of the history
  logic signed [DATA_W-1:0] hist_mem [HISTORY_DEPTH];
  int hist_top = 0;
  int hist_cnt = 0;

  int error_cnt = 0;
  int in_cnt = 0;
  int out_cnt = 0;
  int full_pushes = 0;
  int idle_cycles = 0;
  int status_hits [5] = '{default: 0};
  bit in_xfer = 1'b0;

  int burst_left = 1;
  int gap_left = 0;
  calc_cmd_t next_cmd;

  stall_mode_t stall_mode = STALL_NONE;
  int phase_left = 0;
  int run_left = 0;
  bit run_stall = 1'b0;

  accumulator_alu_with_undo_stack u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_operator       (in_operator),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_status        (out_status),
    .out_history_count (out_history_count)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Advance the history for one command and return its result
  function automatic calc_result_t predict_calc(input calc_cmd_t c);
    calc_result_t r;
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] res;
    logic ok;
    r.value = '0;
    r.status = ST_COMPUTED;
    res = '0;
    ok = 1'b1;
    if (c.opcode[1]) begin
      hist_top = 0;
      hist_cnt = 0;
      r.status = ST_EMPTIED;
    end else if (c.opcode == OPC_UNDO) begin
      if (hist_cnt == 0) begin
        r.status = ST_NO_HISTORY;
      end else begin
        hist_top = (hist_top + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
        hist_cnt--;
        if (hist_cnt == 0) begin
          r.status = ST_EMPTIED;
        end else begin
          r.value = hist_mem[hist_top];
          r.status = ST_UNDONE;
        end
      end
    end else begin
      left = (hist_cnt != 0) ? hist_mem[hist_top] : c.operand_a;
      case (c.oper)
        OPER_ADD: res = left + c.operand_b;
        OPER_SUB: res = left - c.operand_b;
        OPER_MUL: res = left * c.operand_b;
        OPER_DIV: begin
          if (c.operand_b == '0) ok = 1'b0;
          else if (left == DATA_MIN && c.operand_b == DATA_NEG_ONE) res = DATA_MIN;
          else res = left / c.operand_b;
        end
        OPER_REM: begin
          if (c.operand_b == '0) ok = 1'b0;
          else if (left == DATA_MIN && c.operand_b == DATA_NEG_ONE) res = '0;
          else res = left % c.operand_b;
        end
        default: res = left;
      endcase
      if (ok) begin
        // A full history loses its oldest entry
        if (hist_cnt == HISTORY_DEPTH) full_pushes++;
        hist_top = (hist_top + 1) % HISTORY_DEPTH;
        hist_mem[hist_top] = res;
        if (hist_cnt < HISTORY_DEPTH) hist_cnt++;
        r.value = res;
      end else begin
        r.status = ST_DIV_ZERO;
      end
    end
    r.count = COUNT_W'(hist_cnt);
    return r;
  endfunction

  function automatic void queue_cmd(input logic [OPC_W-1:0] opc, input logic [OPER_W-1:0] oper,
                                    input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
    calc_cmd_t c;
    c.opcode = opc;
    c.oper = oper;
    c.operand_a = a;
    c.operand_b = b;
    cmd_queue.push_back(c);
  endfunction

  // Favour zero, the extremes and small values over plain random words
  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DATA_NEG_ONE;
      2: return DATA_MIN;
      3: return DATA_MAX;
      4, 5: return $signed($urandom_range(0, 20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OPER_W-1:0] pick_operator();
    if ($urandom_range(0, 9) == 0) begin
      return OPER_W'($urandom_range(OPER_PASS_FIRST, OPER_PASS_LAST));
    end
    return OPER_W'($urandom_range(OPER_ADD, OPER_REM));
  endfunction

  function automatic logic [OPC_W-1:0] pick_reset();
    return $urandom_range(0, 1) ? OPC_RESET : OPC_RESET_ALT;
  endfunction

  task automatic note_failure(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Present commands in bursts; hold a command until its transfer
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_xfer)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        next_cmd = cmd_queue.pop_front();
        in_opcode <= next_cmd.opcode;
        in_operator <= next_cmd.oper;
        in_operand_a <= next_cmd.operand_a;
        in_operand_b <= next_cmd.operand_b;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
  end

  // Stall the result channel: free phases, scattered stalls and long runs
  always @(negedge clk) begin
    if (rst_n) begin
      if (phase_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(40, 300);
      end
      phase_left--;
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_SCATTER: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            run_stall = !run_stall;
            run_left = run_stall ? $urandom_range(1, 30) : $urandom_range(1, 8);
          end
          run_left--;
          out_stall <= run_stall;
        end
      endcase
    end
  end

  // Predict on each command transfer, check each result transfer, watch for a hang
  always @(posedge clk) begin
    calc_cmd_t    c;
    calc_result_t r;
    calc_result_t exp_r;
    bit           out_xfer;
    in_xfer = rst_n && in_valid && !in_stall;
    out_xfer = rst_n && out_valid && !out_stall;
    if (in_xfer) begin
      c.opcode = in_opcode;
      c.oper = in_operator;
      c.operand_a = in_operand_a;
      c.operand_b = in_operand_b;
      r = predict_calc(c);
      pending_results.push_back(r);
      status_hits[r.status]++;
      in_cnt++;
    end
    if (out_xfer) begin
      out_cnt++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result %0d arrived with none expected: value %0d status %0d",
                               out_cnt, out_value, out_status));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_value !== exp_r.value || out_status !== exp_r.status ||
            out_history_count !== exp_r.count) begin
          note_failure($sformatf(
            "result %0d: value %0d/%0d status %0d/%0d count %0d/%0d (expected/actual)",
            out_cnt, exp_r.value, out_value, exp_r.status, out_status,
            exp_r.count, out_history_count));
        end
      end
    end
    if (rst_n) begin
      if (in_xfer || out_xfer) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int seq_kind;
    int seq_len;
    int roll;
    logic [OPC_W-1:0] opc;

    // Directed: empty undo, overflow wrap, divide corners, pass-through, resets
    queue_cmd(OPC_UNDO, OPER_ADD, DATA_MAX, DATA_MIN);
    queue_cmd(OPC_COMPUTE, OPER_ADD, DATA_MAX, 32'sd1);
    queue_cmd(OPC_COMPUTE, OPER_SUB, '0, 32'sd1);
    queue_cmd(OPC_COMPUTE, OPER_MUL, '0, DATA_MAX);
    queue_cmd(OPC_COMPUTE, OPER_MUL, '0, DATA_MIN);
    queue_cmd(OPC_COMPUTE, OPER_DIV, '0, DATA_NEG_ONE);
    queue_cmd(OPC_COMPUTE, OPER_REM, '0, DATA_NEG_ONE);
    queue_cmd(OPC_COMPUTE, OPER_DIV, '0, '0);
    queue_cmd(OPC_COMPUTE, OPER_REM, '0, '0);
    queue_cmd(OPC_COMPUTE, OPER_PASS_FIRST, '0, DATA_MAX);
    queue_cmd(OPC_COMPUTE, OPER_PASS_FIRST + 3'd1, '0, DATA_MIN);
    queue_cmd(OPC_COMPUTE, OPER_PASS_LAST, '0, DATA_NEG_ONE);
    queue_cmd(OPC_RESET, OPER_ADD, '0, '0);
    queue_cmd(OPC_COMPUTE, OPER_PASS_LAST, DATA_MIN, 32'sd3);
    queue_cmd(OPC_RESET_ALT, OPER_ADD, '0, '0);
    queue_cmd(OPC_COMPUTE, OPER_DIV, -32'sd7, 32'sd2);
    queue_cmd(OPC_COMPUTE, OPER_REM, '0, 32'sd2);
    queue_cmd(OPC_COMPUTE, OPER_DIV, '0, DATA_MIN);
    queue_cmd(OPC_UNDO, OPER_ADD, '0, '0);
    queue_cmd(OPC_UNDO, OPER_ADD, '0, '0);
    queue_cmd(OPC_UNDO, OPER_ADD, '0, '0);
    queue_cmd(OPC_UNDO, OPER_ADD, '0, '0);
    queue_cmd(OPC_RESET, OPER_ADD, '0, '0);

    // Random: build-ups that fill the history, unwinds, and mixed noise
    while (cmd_queue.size() < ITEM_TARGET) begin
      seq_kind = $urandom_range(0, 9);
      seq_len = $urandom_range(4, 30);
      repeat (seq_len) begin
        roll = $urandom_range(0, 19);
        if (seq_kind < 5) opc = (roll < 17) ? OPC_COMPUTE : (roll < 19) ? OPC_UNDO : pick_reset();
        else if (seq_kind < 7) opc = (roll < 16) ? OPC_UNDO : OPC_COMPUTE;
        else opc = (roll < 8) ? OPC_COMPUTE : (roll < 14) ? OPC_UNDO : pick_reset();
        queue_cmd(opc, pick_operator(), pick_operand(), pick_operand());
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every command transferred, every result back, then a quiet spell
    while (cmd_queue.size() != 0 || in_valid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("covered %0d commands and %0d results, %0d pushes onto a full history",
             in_cnt, out_cnt, full_pushes);
    $display("by status: computed %0d, undone %0d, emptied %0d, no history %0d, div zero %0d",
             status_hits[ST_COMPUTED], status_hits[ST_UNDONE], status_hits[ST_EMPTIED],
             status_hits[ST_NO_HISTORY], status_hits[ST_DIV_ZERO]);
    if (error_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/accu_pkg.sv
rtl/accu_div.sv
rtl/accu_dpath.sv
rtl/accu_ctrl.sv
rtl/accumulator_alu_with_undo_stack.sv
sim/accumulator_alu_with_undo_stack_tb.sv
